FILE: rtl/core/mmfr_pkg.sv
// Shared types, constants and arithmetic helpers for the MUSCL minmod face reconstruction core.
package mmfr_pkg;

  // Value and index widths.
  localparam int DATA_W  = 32;
  localparam int SLOPE_W = DATA_W + 1;
  localparam int SUM_W   = DATA_W + 2;
  localparam int FACE_W  = 10;
  localparam int CNT_W   = 11;

  // Sweep length limit: the node that arrives at this count closes the sweep.
  localparam int MAX_NODES = 1024;
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MAX_NODES - 1);
  localparam logic [CNT_W-1:0] INNER_COUNT = CNT_W'(2);

  // Job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic signed [SLOPE_W-1:0] slope_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  // Operands of one variable for the faces that one node closes.
  typedef struct packed {
    data_t  older;   // node i
    slope_t pend;    // limited slope of node i
    data_t  recent;  // node i+1
    slope_t slope;   // limited slope of node i+1
    data_t  node;    // the node just received
  } var_job_t;

  // One queued job: an inner face, a final face, or both.
  typedef struct packed {
    logic              need_normal;
    logic              need_final;
    logic [FACE_W-1:0] final_idx;
    var_job_t          first;
    var_job_t          second;
  } job_t;

  // One result transaction.
  typedef struct packed {
    logic [FACE_W-1:0] face_index;
    data_t             first_left;
    data_t             first_right;
    data_t             second_left;
    data_t             second_right;
    logic              last_of_run;
    logic              last_face;
  } result_t;

  // Minmod: zero on opposite signs or a zero operand, else the smaller magnitude.
  function automatic slope_t minmod(slope_t a, slope_t b);
    slope_t r;
    r = '0;
    if (!a[SLOPE_W-1] && (a != '0) && !b[SLOPE_W-1] && (b != '0)) begin
      r = (a < b) ? a : b;
    end else if (a[SLOPE_W-1] && b[SLOPE_W-1]) begin
      r = (a > b) ? a : b;
    end
    return r;
  endfunction

  // Halving rounds toward minus infinity.
  function automatic slope_t half(slope_t x);
    return x >>> 1;
  endfunction

  // Clamp a widened sum to the signed data range.
  function automatic data_t saturate(sum_t x);
    logic [SUM_W-DATA_W:0] top;
    data_t                 r;
    top = x[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      r = $signed(x[DATA_W-1:0]);
    end else if (x[SUM_W-1]) begin
      r = DATA_MIN;
    end else begin
      r = DATA_MAX;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/muscl_minmod_face_reconstruction_core.sv
// Top level of the MUSCL minmod face reconstruction core.
// Nodes enter one a cycle while full is low, through a queue-style port, into the front
// part, which holds the three-node window and the minmod slopes; results leave one face a
// cycle while they are taken, from the back part through its output register, so a sweep
// of N nodes yields N-1 faces. The last node of a sweep of three or more nodes yields two
// faces and so holds the back part for both; the four-entry job queue between the two parts
// absorbs that, and full rises only once the result side has stalled long enough to fill it.
// The first result of a node passes through the job queue and then the output register.
module muscl_minmod_face_reconstruction_core
  import mmfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  data_t             first_value,
  input  data_t             second_value,
  input  logic              last_node,
  output logic              empty,
  input  logic              pop,
  output logic [FACE_W-1:0] face_index,
  output data_t             first_left,
  output data_t             first_right,
  output data_t             second_left,
  output data_t             second_right,
  output logic              last_of_run,
  output logic              last_face
);

  logic q_full;
  logic q_push;
  job_t q_wr_job;
  logic q_pop;
  logic q_valid;
  job_t q_rd_job;

  // Window and slope front part.
  mmfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .first_value  (first_value),
    .second_value (second_value),
    .last_node    (last_node),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_wr_job)
  );

  // Job queue.
  mmfr_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_job   (q_wr_job),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_rd_job)
  );

  // Face state back part.
  mmfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_rd_job),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .face_index   (face_index),
    .first_left   (first_left),
    .first_right  (first_right),
    .second_left  (second_left),
    .second_right (second_right),
    .last_of_run  (last_of_run),
    .last_face    (last_face)
  );

endmodule

FILE: rtl/core/mmfr_front.sv
// Front part: takes node transactions, keeps the three-node window and queues face jobs.
module mmfr_front
  import mmfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  data_t first_value,
  input  data_t second_value,
  input  logic  last_node,
  input  logic  q_full,
  output logic  q_push,
  output job_t  q_job
);

  logic [CNT_W-1:0] node_count;
  data_t            first_older;
  data_t            first_recent;
  slope_t           first_pend;
  data_t            second_older;
  data_t            second_recent;
  slope_t           second_pend;

  logic   accept;
  logic   last;
  logic   inner;
  slope_t first_slope;
  slope_t second_slope;

  // Classify the node and build the job it causes.
  always_comb begin
    accept = push && !q_full;
    last   = last_node || (node_count >= LAST_COUNT);
    inner  = node_count >= INNER_COUNT;

    // End nodes carry no slope, so none is formed while the first two nodes of a sweep arrive.
    first_slope  = '0;
    second_slope = '0;
    if (inner) begin
      first_slope  = minmod(slope_t'(first_value) - slope_t'(first_recent),
                            slope_t'(first_recent) - slope_t'(first_older));
      second_slope = minmod(slope_t'(second_value) - slope_t'(second_recent),
                            slope_t'(second_recent) - slope_t'(second_older));
    end

    q_job.need_normal   = inner;
    q_job.need_final    = last && (node_count != '0);
    q_job.final_idx     = node_count[FACE_W-1:0] - FACE_W'(1);
    q_job.first.older   = first_older;
    q_job.first.pend    = first_pend;
    q_job.first.recent  = first_recent;
    q_job.first.slope   = first_slope;
    q_job.first.node    = first_value;
    q_job.second.older  = second_older;
    q_job.second.pend   = second_pend;
    q_job.second.recent = second_recent;
    q_job.second.slope  = second_slope;
    q_job.second.node   = second_value;

    q_push = accept && (q_job.need_normal || q_job.need_final);
    full   = q_full;
  end

  // Node counter: the last node of a sweep restarts it.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (accept) begin
      if (last) begin
        node_count <= '0;
      end else begin
        node_count <= node_count + CNT_W'(1);
      end
    end
  end

  // Window shift; stale values are never read before being overwritten.
  always_ff @(posedge clk) begin
    if (accept) begin
      first_older   <= first_recent;
      first_recent  <= first_value;
      first_pend    <= first_slope;
      second_older  <= second_recent;
      second_recent <= second_value;
      second_pend   <= second_slope;
    end
  end

endmodule

FILE: rtl/core/mmfr_job_queue.sv
// Short job queue in flip-flops that decouples the front and back parts.
module mmfr_job_queue
  import mmfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  input  logic rd_en,
  output logic rd_valid,
  output job_t rd_job
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign q_full   = fill == QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_job   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

FILE: rtl/core/mmfr_back.sv
// Back part: turns queued jobs into saturated left and right face states, one face a cycle while results are taken.
module mmfr_back
  import mmfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [FACE_W-1:0] face_index,
  output data_t             first_left,
  output data_t             first_right,
  output data_t             second_left,
  output data_t             second_right,
  output logic              last_of_run,
  output logic              last_face
);

  logic    out_valid;
  result_t out_res;
  logic    on_final;
  logic    load;
  logic    do_final;
  result_t res;

  // Face states of one variable for the face selected by do_final.
  function automatic void face_states(input var_job_t v, input logic fin,
                                      output data_t left, output data_t right);
    data_t  base;
    slope_t step;
    base  = fin ? v.recent : v.older;
    step  = fin ? half(v.slope) : half(v.pend);
    left  = saturate(sum_t'(base) + sum_t'(step));
    right = fin ? v.node : saturate(sum_t'(v.recent) - sum_t'(half(v.slope)));
  endfunction

  // Select the face of the head job and form its result.
  always_comb begin
    load     = q_valid && (!out_valid || pop);
    do_final = on_final || !q_job.need_normal;
    q_pop    = load && (do_final || !q_job.need_final);

    res.face_index  = do_final ? q_job.final_idx : q_job.final_idx - FACE_W'(1);
    res.last_of_run = do_final || !q_job.need_final;
    res.last_face   = do_final;
    face_states(q_job.first, do_final, res.first_left, res.first_right);
    face_states(q_job.second, do_final, res.second_left, res.second_right);
  end

  // Output register valid flag and face phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      on_final  <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        on_final  <= !q_pop;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign empty        = !out_valid;
  assign face_index   = out_res.face_index;
  assign first_left   = out_res.first_left;
  assign first_right  = out_res.first_right;
  assign second_left  = out_res.second_left;
  assign second_right = out_res.second_right;
  assign last_of_run  = out_res.last_of_run;
  assign last_face    = out_res.last_face;

endmodule

FILE: rtl/core/mmfr_checker.sv
// Port-level checker for the MUSCL minmod face reconstruction core, with its bind.
module mmfr_checker
  import mmfr_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [FACE_W-1:0] face_index,
  input logic              last_of_run,
  input logic              last_face
);

  logic              seen;
  logic [FACE_W-1:0] prev_idx;

  // Track the index of the last face taken within the current sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= 1'b0;
      prev_idx <= '0;
    end else if (pop && !empty) begin
      seen     <= !last_face;
      prev_idx <= face_index;
    end
  end

  // Reset leaves both sides of the block idle.
  assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("core not idle after reset");

  // The final face of a sweep is always the final result of its transaction.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && last_face) |-> last_of_run)
    else $error("final face not marked as last of run");

  // Faces of a sweep come out in order from zero.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (face_index == (seen ? prev_idx + FACE_W'(1) : '0)))
    else $error("face index out of sequence");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(face_index) && $stable(last_face)))
    else $error("waiting result changed");

endmodule

bind muscl_minmod_face_reconstruction_core mmfr_checker u_mmfr_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .face_index  (face_index),
  .last_of_run (last_of_run),
  .last_face   (last_face)
);

FILE: sim/muscl_minmod_face_reconstruction_core_test.sv
// Self-checking testbench for the MUSCL minmod face reconstruction core.
module muscl_minmod_face_reconstruction_core_test
  import mmfr_pkg::*;
();

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_NODES = 250;
  localparam int LONG_SWEEP   = 1030;
  localparam int REPORT_LIMIT = 10;

  // How the node values of one variable are generated over a sweep.
  typedef enum int {FILL_RANDOM, FILL_RAMP, FILL_EXTREME, FILL_STEPS} fill_t;

  // One row of the directed stimulus, with an optional face typed in by hand.
  typedef struct packed {
    data_t   first;
    data_t   second;
    logic    mark;
    logic    given;
    result_t face;
  } node_row_t;

  localparam int NUM_ROWS = 19;
  localparam node_row_t DIRECTED_NODES [NUM_ROWS] = '{
    // Single-node sweep: closes without a face.
    '{32'sd5, -32'sd7, 1'b1, 1'b0, '0},
    // Two-node sweep: one face with both slopes zero.
    '{32'sd100, -32'sd100, 1'b0, 1'b0, '0},
    '{DATA_MAX, DATA_MIN, 1'b1, 1'b1,
      '{10'd0, 32'sd100, DATA_MAX, -32'sd100, DATA_MIN, 1'b1, 1'b1}},
    // Alternating extremes: every slope is limited to zero.
    '{DATA_MIN, DATA_MAX, 1'b0, 1'b0, '0},
    '{DATA_MAX, DATA_MIN, 1'b0, 1'b0, '0},
    '{DATA_MIN, DATA_MAX, 1'b0, 1'b1,
      '{10'd0, DATA_MIN, DATA_MAX, DATA_MAX, DATA_MIN, 1'b1, 1'b0}},
    '{DATA_MAX, DATA_MIN, 1'b1, 1'b0, '0},
    // Full-range ramp on one variable, a plateau and falling steps on the other.
    '{DATA_MIN, 32'sd0, 1'b0, 1'b0, '0},
    '{-32'sd1073741824, -32'sd3, 1'b0, 1'b0, '0},
    '{32'sd0, -32'sd3, 1'b0, 1'b0, '0},
    '{32'sd1073741824, -32'sd7, 1'b0, 1'b0, '0},
    '{DATA_MAX, -32'sd12, 1'b1, 1'b0, '0},
    // Odd slopes of both signs, so halving rounds downwards.
    '{32'sd1, -32'sd1, 1'b0, 1'b0, '0},
    '{32'sd2, -32'sd2, 1'b0, 1'b0, '0},
    '{32'sd4, -32'sd4, 1'b0, 1'b0, '0},
    '{32'sd7, -32'sd7, 1'b1, 1'b0, '0},
    // All ones against all zeros.
    '{-32'sd1, 32'sd0, 1'b0, 1'b0, '0},
    '{32'sd0, -32'sd1, 1'b0, 1'b0, '0},
    '{-32'sd1, 32'sd0, 1'b1, 1'b0, '0}
  };

  localparam data_t EXTREMES [6] = '{DATA_MIN, DATA_MAX, 32'sd0, -32'sd1, 32'sd1,
                                     DATA_MIN + 32'sd1};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  data_t             first_value = '0;
  data_t             second_value = '0;
  logic              last_node = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [FACE_W-1:0] face_index;
  data_t             first_left;
  data_t             first_right;
  data_t             second_left;
  data_t             second_right;
  logic              last_of_run;
  logic              last_face;

  // Window of the predictor: two previous nodes and the slope of the older one.
  longint older_node [2] = '{0, 0};
  longint recent_node [2] = '{0, 0};
  longint pend_slope [2] = '{0, 0};
  int     nodes_seen = 0;

  result_t faces_due [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      hold_requests = 0;
  int      holds_served = 0;
  int      push_stretch = 0;
  logic    push_idle = 1'b0;
  int      pop_stretch = 0;
  logic    pop_idle = 1'b0;

  muscl_minmod_face_reconstruction_core dut (.*);

  // Clock with a 20-unit period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Free-running cycle counter for the run limit.
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : run_limit
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Minmod of the forward and backward differences.
  function automatic longint limited_slope(longint fwd, longint bwd);
    if (fwd > 0 && bwd > 0) return (fwd < bwd) ? fwd : bwd;
    if (fwd < 0 && bwd < 0) return (fwd > bwd) ? fwd : bwd;
    return 0;
  endfunction

  function automatic data_t clamp_data(longint x);
    if (x > longint'(DATA_MAX)) return DATA_MAX;
    if (x < longint'(DATA_MIN)) return DATA_MIN;
    return data_t'(x);
  endfunction

  function automatic result_t make_face(int idx, longint l1, longint r1, longint l2,
                                        longint r2, logic run_end, logic sweep_end);
    result_t f;
    f.face_index   = FACE_W'(idx);
    f.first_left   = clamp_data(l1);
    f.first_right  = clamp_data(r1);
    f.second_left  = clamp_data(l2);
    f.second_right = clamp_data(r2);
    f.last_of_run  = run_end;
    f.last_face    = sweep_end;
    return f;
  endfunction

  function automatic void clear_window();
    older_node  = '{0, 0};
    recent_node = '{0, 0};
    pend_slope  = '{0, 0};
    nodes_seen  = 0;
  endfunction

  // Advances the window by one node and returns the number of faces it closes.
  function automatic int reconstruct_node(input data_t a, input data_t b, input logic mark,
                                          output result_t f0, output result_t f1);
    longint fresh [2];
    longint s [2];
    logic   closing;
    int     n;
    fresh[0] = a;
    fresh[1] = b;
    closing = mark || (nodes_seen >= MAX_NODES - 1);
    f0 = '0;
    f1 = '0;
    n = 0;
    if (nodes_seen == 0) begin
      if (closing) begin
        clear_window();
      end else begin
        recent_node = fresh;
        pend_slope  = '{0, 0};
        nodes_seen  = 1;
      end
    end else if (nodes_seen == 1) begin
      if (closing) begin
        f0 = make_face(0, recent_node[0], fresh[0], recent_node[1], fresh[1], 1'b1, 1'b1);
        n = 1;
        clear_window();
      end else begin
        older_node  = recent_node;
        recent_node = fresh;
        pend_slope  = '{0, 0};
        nodes_seen  = 2;
      end
    end else begin
      for (int v = 0; v < 2; v++)
        s[v] = limited_slope(fresh[v] - recent_node[v], recent_node[v] - older_node[v]);
      f0 = make_face(nodes_seen - 2,
                     older_node[0] + (pend_slope[0] >>> 1), recent_node[0] - (s[0] >>> 1),
                     older_node[1] + (pend_slope[1] >>> 1), recent_node[1] - (s[1] >>> 1),
                     !closing, 1'b0);
      n = 1;
      if (closing) begin
        f1 = make_face(nodes_seen - 1,
                       recent_node[0] + (s[0] >>> 1), fresh[0],
                       recent_node[1] + (s[1] >>> 1), fresh[1], 1'b1, 1'b1);
        n = 2;
        clear_window();
      end else begin
        older_node  = recent_node;
        recent_node = fresh;
        pend_slope  = s;
        nodes_seen  = nodes_seen + 1;
      end
    end
    return n;
  endfunction

  // Gap before the next transaction, in stretches that either idle or run flat out.
  function automatic int draw_gap(inout int stretch, inout logic idle);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 60);
      idle = ($urandom_range(0, 2) != 0);
    end
    stretch--;
    return idle ? int'($urandom_range(0, 17)) : 0;
  endfunction

  function automatic data_t node_value(fill_t mode, longint base, longint step, int k);
    longint v;
    case (mode)
      FILL_RANDOM:  v = longint'($signed($urandom));
      FILL_RAMP:    v = base + step * k + longint'(int'($urandom_range(0, 6)) - 3);
      FILL_EXTREME: v = longint'(EXTREMES[$urandom_range(0, 5)]);
      default:      v = base + step * (k / 2);
    endcase
    return data_t'(v);
  endfunction

  // Offers one node and records the faces it must produce once it is taken.
  task automatic send_node(input data_t a, input data_t b, input logic mark,
                           input logic given, input result_t given_face);
    int      gap;
    int      n;
    result_t f0;
    result_t f1;
    gap = draw_gap(push_stretch, push_idle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    first_value  <= a;
    second_value <= b;
    last_node    <= mark;
    do @(posedge clk); while (full);
    n = reconstruct_node(a, b, mark, f0, f1);
    if (given) f0 = given_face;
    if (n > 0) faces_due = {faces_due, f0};
    if (n > 1) faces_due = {faces_due, f1};
  endtask

  // Plays one sweep of random content; an unmarked sweep relies on the length cut-off.
  task automatic send_sweep(input int len, input logic marked);
    fill_t  mode [2];
    longint base [2];
    longint step [2];
    for (int v = 0; v < 2; v++) begin
      mode[v] = fill_t'($urandom_range(0, 3));
      base[v] = longint'($signed($urandom));
      if ($urandom_range(0, 3) == 0) begin
        step[v] = longint'($signed($urandom)) >>> 3;
      end else begin
        step[v] = longint'(int'($urandom_range(0, 2000)) - 1000);
      end
    end
    for (int k = 0; k < len; k++)
      send_node(node_value(mode[0], base[0], step[0], k),
                node_value(mode[1], base[1], step[1], k),
                marked && (k == len - 1), 1'b0, '0);
  endtask

  // Node side: reset, directed rows, random sweeps, then one overlong sweep.
  initial begin : node_side
    int sent;
    int len;
    sent = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_ROWS; r++)
      send_node(DIRECTED_NODES[r].first, DIRECTED_NODES[r].second, DIRECTED_NODES[r].mark,
                DIRECTED_NODES[r].given, DIRECTED_NODES[r].face);

    while (sent < RANDOM_NODES) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = 2;
        2, 3:    len = $urandom_range(13, 40);
        default: len = $urandom_range(3, 12);
      endcase
      // Partway through, the result side holds off so that the core backs up.
      if (sent >= 100 && hold_requests == 0) hold_requests = 1;
      send_sweep(len, 1'b1);
      sent += len;
    end

    // Overlong sweep: the cut-off closes it, and the remainder starts a fresh sweep.
    send_sweep(LONG_SWEEP, 1'b1);
    push <= 1'b0;

    while (faces_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && faces_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: takes faces with random gaps and checks each against the oldest expectation.
  initial begin : result_side
    int      gap;
    result_t seen;
    result_t want;
    do @(posedge clk); while (rst);
    forever begin
      gap = draw_gap(pop_stretch, pop_idle);
      if (hold_requests > holds_served) begin
        holds_served++;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      seen = '{face_index, first_left, first_right, second_left, second_right,
               last_of_run, last_face};
      if (faces_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected face transaction: index %0d", seen.face_index);
      end else begin
        want = faces_due.pop_front();
        if (seen.face_index !== want.face_index || seen.first_left !== want.first_left ||
            seen.first_right !== want.first_right || seen.second_left !== want.second_left ||
            seen.second_right !== want.second_right ||
            seen.last_of_run !== want.last_of_run || seen.last_face !== want.last_face) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("face mismatch, expected: idx %0d L1 %0d R1 %0d L2 %0d R2 %0d run %b last %b",
                     want.face_index, want.first_left, want.first_right, want.second_left,
                     want.second_right, want.last_of_run, want.last_face);
            $display("               actual:   idx %0d L1 %0d R1 %0d L2 %0d R2 %0d run %b last %b",
                     seen.face_index, seen.first_left, seen.first_right, seen.second_left,
                     seen.second_right, seen.last_of_run, seen.last_face);
          end
        end
      end
    end
  end

endmodule
